// ===== src/siphash_2_4_stream_defines.svh =====
// Assertion macros shared by the SipHash stream block.
`ifndef SIPHASH_2_4_STREAM_DEFINES_SVH
`define SIPHASH_2_4_STREAM_DEFINES_SVH

// Same-cycle implication, checked on clk with reset masked.
`define SH24_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("siphash stream: same-cycle check failed");

// Next-cycle implication, checked on clk with reset masked.
`define SH24_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("siphash stream: next-cycle check failed");

`endif

// ===== src/sh24_pkg.sv =====
// Shared types and constants of the SipHash-2-4 stream block.
package sh24_pkg;

	// SipHash initialization constants
	localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
	localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
	localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
	localparam logic [63:0] SIP_C3 = 64'h7465646279746573;

	// configuration register indexes
	localparam logic REG_KEY_LOW  = 1'b0;
	localparam logic REG_KEY_HIGH = 1'b1;

	// default depth of the command queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// step code of the last finalization round in the back end
	localparam logic [2:0] LAST_STEP = 3'd7;

	// one classified command for the round engine
	typedef struct packed {
		logic        start;        // reload chain from the key first
		logic        absorb_word;  // absorb word as a full block
		logic        finalize;     // absorb fin_word, finalize, emit hash
		logic [63:0] word;
		logic [63:0] fin_word;     // tail bytes plus length byte
	} cmd_t;

	// back end status, for checks at the top level
	typedef struct packed {
		logic       active;
		logic [2:0] step;
	} back_status_t;

endpackage

// ===== src/sh24_front.sv =====
// Front end: accepts message words, tracks length, builds round commands.
module sh24_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [63:0]       data_word,
	input  logic [3:0]        byte_count,
	input  logic              last_item,
	input  logic              q_full,
	output logic              push,
	output sh24_pkg::cmd_t    cmd
);

	logic [7:0]  length_q;
	logic        open_q;
	logic [3:0]  n_bytes;
	logic        full_blk;
	logic [7:0]  len_base;
	logic [7:0]  len_new;
	logic [63:0] tail;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	// classify the word and build the final block
	always_comb begin
		n_bytes  = (byte_count > 4'd8) ? 4'd8 : byte_count;
		full_blk = !last_item || (n_bytes == 4'd8);
		len_base = open_q ? length_q : 8'd0;
		len_new  = len_base + (full_blk ? 8'd8 : {4'd0, n_bytes});
		for (int i = 0; i < 8; i++) begin
			tail[8*i +: 8] = (4'(i) < n_bytes) ? data_word[8*i +: 8] : 8'h00;
		end
		cmd.start       = !open_q;
		cmd.absorb_word = full_blk;
		cmd.finalize    = last_item;
		cmd.word        = data_word;
		cmd.fin_word    = {len_new, (full_blk ? 56'd0 : tail[55:0])};
	end

	// message length and open flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= 8'd0;
			open_q   <= 1'b0;
		end else if (push) begin
			length_q <= len_new;
			open_q   <= !last_item;
		end
	end

endmodule

// ===== src/sh24_queue.sv =====
// Short command queue between the front and back ends.
module sh24_queue #(
	parameter int DEPTH = sh24_pkg::QUEUE_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  sh24_pkg::cmd_t               push_cmd,
	input  logic                         pop,
	output logic                         head_valid,
	output sh24_pkg::cmd_t               head,
	output logic                         full,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	sh24_pkg::cmd_t  mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign head_valid = (count_q != '0);
	assign full       = (count_q == CW'(DEPTH));
	assign count      = count_q;
	assign head       = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ===== src/sh24_back.sv =====
// Back end: SipRound engine, one round per cycle unless it stalls, plus the hash register.
module sh24_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [63:0]             key_low,
	input  logic [63:0]             key_high,
	input  logic                    head_valid,
	input  sh24_pkg::cmd_t          head,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [63:0]             hash_value,
	output sh24_pkg::back_status_t  status
);

	typedef logic [3:0][63:0] vars_t;

	// W: word absorb rounds, F: final block rounds, R: finalization rounds
	typedef enum logic [2:0] {
		STEP_W0, STEP_W1, STEP_F0, STEP_F1,
		STEP_R0, STEP_R1, STEP_R2, STEP_R3 = sh24_pkg::LAST_STEP
	} step_t;

	function automatic vars_t mix_round(vars_t v);
		logic [63:0] a, b, c, d;
		a = v[0]; b = v[1]; c = v[2]; d = v[3];
		a = a + b; b = {b[50:0], b[63:51]}; b = b ^ a; a = {a[31:0], a[63:32]};
		c = c + d; d = {d[47:0], d[63:48]}; d = d ^ c;
		c = c + b; b = {b[46:0], b[63:47]}; b = b ^ c; c = {c[31:0], c[63:32]};
		a = a + d; d = {d[42:0], d[63:43]}; d = d ^ a;
		mix_round = {d, c, b, a};
	endfunction

	vars_t       v_q;
	step_t       step_q;
	logic        active_q;
	logic        out_valid_q;
	logic [63:0] hash_q;

	step_t       cur_step;
	vars_t       v_in;
	vars_t       pre;
	vars_t       rnd;
	vars_t       post;
	logic        is_end;
	logic        go;

	// select step and chain input, one SipRound with its xors
	always_comb begin
		if (active_q) begin
			cur_step = step_q;
		end else begin
			cur_step = head.absorb_word ? STEP_W0 : STEP_F0;
		end
		if (!active_q && head.start) begin
			v_in[0] = key_low  ^ sh24_pkg::SIP_C0;
			v_in[1] = key_high ^ sh24_pkg::SIP_C1;
			v_in[2] = key_low  ^ sh24_pkg::SIP_C2;
			v_in[3] = key_high ^ sh24_pkg::SIP_C3;
		end else begin
			v_in = v_q;
		end
		pre = v_in;
		unique case (cur_step)
			STEP_W0: pre[3] = v_in[3] ^ head.word;
			STEP_F0: pre[3] = v_in[3] ^ head.fin_word;
			STEP_R0: pre[2] = v_in[2] ^ 64'h00000000000000ff;
			default: pre = v_in;
		endcase
		rnd  = mix_round(pre);
		post = rnd;
		unique case (cur_step)
			STEP_W1: post[0] = rnd[0] ^ head.word;
			STEP_F1: post[0] = rnd[0] ^ head.fin_word;
			default: post = rnd;
		endcase
		is_end = ((cur_step == STEP_W1) && !head.finalize) || (cur_step == STEP_R3);
		// the last round waits for a free hash register
		go  = head_valid && !((cur_step == STEP_R3) && out_valid_q && !out_ready);
		pop = go && is_end;
	end

	// sequencer state, chain and hash register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q         <= '0;
			step_q      <= STEP_W0;
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
			hash_q      <= '0;
		end else begin
			if (go) begin
				v_q      <= post;
				active_q <= !is_end;
				step_q   <= step_t'(cur_step + 3'd1);
			end
			if (go && (cur_step == STEP_R3)) begin
				out_valid_q <= 1'b1;
				hash_q      <= rnd[0] ^ rnd[1] ^ rnd[2] ^ rnd[3];
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign hash_value    = hash_q;
	assign status.active = active_q;
	assign status.step   = step_q;

endmodule

// ===== src/siphash_2_4_stream.sv =====
// Top level of the SipHash-2-4 stream hasher.
//
//  channel   signals                                   direction  accepted when
//  input     in_valid/in_ready, data_word, byte_count,  in         in_valid && in_ready
//            last_item
//  output    out_valid/out_ready, hash_value            out        out_valid && out_ready
//  config    cfg_we, cfg_index, cfg_data                in         cfg_we
//
// The engine does one SipRound per cycle unless stalled: absorb rounds W0-W1 for a full
// word; final block F0-F1 and finalization R0-R3 for a last one, all three if full.
// Reset clears all but the queue storage; the first word after it reloads the chain from the key.
// The command queue (DEPTH words) lets the front accept while the engine runs; the
// engine holds in its last finalization round while the previous hash is not taken.
`include "siphash_2_4_stream_defines.svh"

module siphash_2_4_stream #(
	parameter int DEPTH = sh24_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] data_word,
	input  logic [3:0]  byte_count,
	input  logic        last_item,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] hash_value,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [63:0]                 key_low_q;
	logic [63:0]                 key_high_q;
	logic                        push;
	sh24_pkg::cmd_t              push_cmd;
	logic                        q_full;
	logic                        head_valid;
	sh24_pkg::cmd_t              head;
	logic                        pop;
	logic [CW-1:0]               q_count;
	sh24_pkg::back_status_t      back_st;

	// key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sh24_pkg::REG_KEY_LOW:  key_low_q  <= cfg_data;
				sh24_pkg::REG_KEY_HIGH: key_high_q <= cfg_data;
			endcase
		end
	end

	sh24_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_word  (data_word),
		.byte_count (byte_count),
		.last_item  (last_item),
		.q_full     (q_full),
		.push       (push),
		.cmd        (push_cmd)
	);

	sh24_queue #(
		.DEPTH (DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head),
		.full       (q_full),
		.count      (q_count)
	);

	sh24_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.key_low    (key_low_q),
		.key_high   (key_high_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hash_value (hash_value),
		.status     (back_st)
	);

	// engine mid-command always has its command at the queue head
	`SH24_ASSERT_IMP(a_active_has_cmd, back_st.active, q_count != '0)
	// fill count never passes the depth
	`SH24_ASSERT_IMP(a_count_bound, 1'b1, q_count <= CW'(DEPTH))
	// an accepted word is queued on the next cycle
	`SH24_ASSERT_NEXT(a_push_lands, in_valid && in_ready, q_count != '0)
	// a new hash appears only right after the last finalization round
	`SH24_ASSERT_IMP(a_hash_after_final, $rose(out_valid), $past(back_st.active && (back_st.step == sh24_pkg::LAST_STEP)))

endmodule

// ===== verif/tb_siphash_2_4_stream.sv =====
// Self-checking testbench for the SipHash-2-4 stream hasher: directed and random messages.
module tb_siphash_2_4_stream;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DRAIN_CYCLES = 24;   // covers a full last word plus queued commands
	localparam int PHASE_WORDS  = 330;  // random words per key setting
	localparam int HOLD_CYCLES  = 300;  // long receiver hold-off

	// Running SipHash-2-4 of the word stream and the queue of hashes it predicts
	class hash_scoreboard;
		logic [63:0] key0, key1;
		logic [63:0] v[4];
		logic [7:0]  len_mod;
		bit          msg_open;
		int          msg_bytes;
		logic [63:0] expected_hashes[$];
		int          words_seen, messages_seen, long_messages, hashes_checked;

		function new();
			key0 = '0;
			key1 = '0;
			len_mod = '0;
			msg_open = 1'b0;
			msg_bytes = 0;
			words_seen = 0;
			messages_seen = 0;
			long_messages = 0;
			hashes_checked = 0;
		endfunction

		function void set_key(input logic idx, input logic [63:0] val);
			if (idx == sh24_pkg::REG_KEY_LOW)
				key0 = val;
			else
				key1 = val;
		endfunction

		function logic [63:0] rotl(input logic [63:0] x, input int b);
			return (x << b) | (x >> (64 - b));
		endfunction

		function void mix_round();
			v[0] += v[1]; v[1] = rotl(v[1], 13); v[1] ^= v[0]; v[0] = rotl(v[0], 32);
			v[2] += v[3]; v[3] = rotl(v[3], 16); v[3] ^= v[2];
			v[2] += v[1]; v[1] = rotl(v[1], 17); v[1] ^= v[2]; v[2] = rotl(v[2], 32);
			v[0] += v[3]; v[3] = rotl(v[3], 21); v[3] ^= v[0];
		endfunction

		function void compress(input logic [63:0] m);
			v[3] ^= m;
			mix_round();
			mix_round();
			v[0] ^= m;
		endfunction

		// advance the hash state by one accepted word
		function void note_word(input logic [63:0] data, input logic [3:0] cnt,
				input logic last);
			int n;
			logic [63:0] fin;
			words_seen++;
			if (!msg_open) begin
				v[0] = key0 ^ sh24_pkg::SIP_C0;
				v[1] = key1 ^ sh24_pkg::SIP_C1;
				v[2] = key0 ^ sh24_pkg::SIP_C2;
				v[3] = key1 ^ sh24_pkg::SIP_C3;
				len_mod = '0;
				msg_bytes = 0;
				msg_open = 1'b1;
			end
			n = (cnt > 4'd8) ? 8 : int'(cnt);
			// words before the last always count as full
			if (!last || n == 8) begin
				compress(data);
				len_mod += 8'd8;
				msg_bytes += 8;
				if (!last)
					return;
				fin = '0;
			end else begin
				fin = (n == 0) ? 64'd0 : (data & (~64'd0 >> (64 - 8 * n)));
				len_mod += 8'(n);
				msg_bytes += n;
			end
			fin |= {len_mod, 56'd0};
			compress(fin);
			v[2] ^= 64'hff;
			repeat (4) mix_round();
			expected_hashes.push_back(v[0] ^ v[1] ^ v[2] ^ v[3]);
			messages_seen++;
			if (msg_bytes >= 256)
				long_messages++;
			msg_open = 1'b0;
		endfunction

		function bit check_hash(input logic [63:0] got, output string why);
			logic [63:0] want;
			why = "";
			if (expected_hashes.size() == 0) begin
				why = $sformatf("hash %h with none expected", got);
				return 1'b0;
			end
			want = expected_hashes.pop_front();
			hashes_checked++;
			if (got !== want) begin
				why = $sformatf("hash_value %h, expected %h", got, want);
				return 1'b0;
			end
			return 1'b1;
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [63:0] data_word = '0;
	logic [3:0]  byte_count = '0;
	logic        last_item = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] hash_value;
	logic        cfg_we = 1'b0;
	logic        cfg_index = sh24_pkg::REG_KEY_LOW;
	logic [63:0] cfg_data = '0;

	int snd_idle_pct = 10;
	int rcv_idle_pct = 74;
	int hold_req = 0;
	int hold_left = 0;
	int mismatch_count = 0;
	int key_settings = 0;

	hash_scoreboard hash_sb = new();

	siphash_2_4_stream DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_word(data_word),
		.byte_count(byte_count),
		.last_item(last_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.hash_value(hash_value),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 100)
			$display("[%0t] MISMATCH: %s", $time, what);
	endtask

	// receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	// result monitor
	always @(posedge clk) begin
		string why;
		if (arst_n && out_valid && out_ready) begin
			if (!hash_sb.check_hash(hash_value, why))
				report_mismatch(why);
		end
	end

	// offer one word; returns after the edge that accepts it
	task automatic send_word(input logic [63:0] data, input logic [3:0] cnt, input logic last);
		@(negedge clk);
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		data_word <= data;
		byte_count <= cnt;
		last_item <= last;
		do @(posedge clk); while (!in_ready);
		hash_sb.note_word(data, cnt, last);
	endtask

	// drop valid and wait for every predicted hash, then let the engine settle
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (hash_sb.expected_hashes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_key(input logic [63:0] k0, input logic [63:0] k1);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= sh24_pkg::REG_KEY_LOW;
		cfg_data <= k0;
		@(posedge clk);
		hash_sb.set_key(sh24_pkg::REG_KEY_LOW, k0);
		@(negedge clk);
		cfg_index <= sh24_pkg::REG_KEY_HIGH;
		cfg_data <= k1;
		@(posedge clk);
		hash_sb.set_key(sh24_pkg::REG_KEY_HIGH, k1);
		@(negedge clk);
		cfg_we <= 1'b0;
		key_settings++;
	endtask

	function automatic logic [63:0] rand_word();
		case ($urandom_range(9))
			0: return 64'd0;
			1: return ~64'd0;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// main stimulus
	initial begin
		int phase;
		int phase_words;
		int len;
		int i;
		bit hold_done;
		bit pause_done;
		logic [3:0] cnt;
		logic [63:0] k0, k1;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		load_key(64'h0706050403020100, 64'h0f0e0d0c0b0a0908);

		// directed: empty messages, every tail length, full last words,
		// out-of-range counts and short words that are not last
		send_word(64'd0, 4'd0, 1'b1);
		send_word(~64'd0, 4'd0, 1'b1);
		for (i = 1; i < 8; i++)
			send_word(64'hfedcba9876543210, 4'(i), 1'b1);
		send_word(~64'd0, 4'd8, 1'b1);
		send_word(64'd0, 4'd8, 1'b1);
		send_word(~64'd0, 4'd15, 1'b1);
		send_word(64'h0706050403020100, 4'd3, 1'b0);
		send_word(~64'd0, 4'd12, 1'b0);
		send_word(64'h0f0e0d0c0b0a0908, 4'd0, 1'b1);
		send_word(64'h0706050403020100, 4'd8, 1'b0);
		send_word(64'h000e0d0c0b0a0908, 4'd7, 1'b1);

		// random messages under several keys and idling regimes
		for (phase = 0; phase < 6; phase++) begin
			wait_drained();
			case (phase)
				0: begin k0 = 64'd0; k1 = 64'd0; end
				1: begin k0 = ~64'd0; k1 = ~64'd0; end
				3: begin k0 = ~64'd0; k1 = 64'd0; end
				4: begin k0 = 64'd0; k1 = ~64'd0; end
				default: begin k0 = {$urandom, $urandom}; k1 = {$urandom, $urandom}; end
			endcase
			load_key(k0, k1);
			snd_idle_pct = (phase < 2) ? 10 : (phase < 4) ? 74 : 0;
			rcv_idle_pct = (phase < 2) ? 74 : (phase < 4) ? 10 : 0;
			phase_words = 0;
			hold_done = 1'b0;
			pause_done = 1'b0;
			while (phase_words < PHASE_WORDS) begin
				if (!hold_done && phase_words >= 100) begin
					hold_req = HOLD_CYCLES;
					hold_done = 1'b1;
				end
				if (!pause_done && phase_words >= 200) begin
					wait_drained();
					pause_done = 1'b1;
				end
				// mostly short messages; a few pass 256 bytes so the length wraps
				len = ($urandom_range(19) == 0) ? $urandom_range(40, 32) : $urandom_range(6, 1);
				for (i = 0; i < len; i++) begin
					if (i == len - 1)
						cnt = 4'($urandom_range(15));
					else
						cnt = ($urandom_range(4) == 0) ? 4'($urandom_range(15)) : 4'd8;
					send_word(rand_word(), cnt, i == len - 1);
				end
				phase_words += len;
			end
		end

		wait_drained();
		$display("Covered %0d words in %0d messages (%0d of 256 bytes or more).",
			hash_sb.words_seen, hash_sb.messages_seen, hash_sb.long_messages);
		$display("Compared %0d hashes under %0d key settings and three idling regimes.",
			hash_sb.hashes_checked, key_settings);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// run limit
	initial begin
		#5000000;
		$display("Timeout with %0d hashes outstanding.", hash_sb.expected_hashes.size());
		$display("Verification failed");
		$finish;
	end

endmodule
